FILE: hw/rtl/tfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfd_pkg
// Types and constants shared by the telemetry frame deframer modules.
// ----------------------------------------------------------------------------
package tfd_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_VALUE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_CODE    = 2'd1;

    localparam logic [7:0] HEADER_RESET    = 8'd253;
    localparam logic [7:0] STOP_CODE_RESET = 8'd20;

    // Payload positions of the frame descriptor bytes
    localparam int POS_TYPE    = 0;
    localparam int POS_COMMAND = 1;
    localparam int POS_SIZE_HI = 2;
    localparam int POS_SIZE_LO = 3;

    // Telemetry fields sit back to back from byte 6 through byte 35.
    localparam int FIELD_ADDR_W = 6;
    localparam logic [FIELD_ADDR_W-1:0] FIRST_FIELD_ADDR = 6'd6;

    localparam logic [3:0] FIELD_LAT  = 4'd9;
    localparam logic [3:0] FIELD_LON  = 4'd10;
    localparam logic [3:0] LAST_FIELD = 4'd12;

    localparam int TDATA_W = 72;

    // One good frame handed from the front to the back.
    typedef struct packed {
        logic        bank;
        logic        stop;
        logic [7:0]  frame_type;
        logic [7:0]  frame_command;
        logic [15:0] frame_size;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_ACC,
        BK_OUT,
        BK_STOP
    } back_state_t;

    // Number of bytes of a field, minus one.
    function automatic logic [1:0] field_last_byte(input logic [3:0] k);
        logic [1:0] n;
        case (k)
            FIELD_LAT, FIELD_LON: n = 2'd3;
            default:              n = 2'd1;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/telemetry_frame_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// telemetry_frame_deframer
// Header-framed telemetry deframer with an XOR checksum.
// ----------------------------------------------------------------------------
// Received bytes enter one word per cycle on the s_ stream. After the header
// byte, PAYLOAD_BYTES payload bytes are collected into one of two buffer
// banks; the last is the checksum, the XOR of the header and all payload
// bytes before it. Failing frames are dropped. A good frame yields 13 result
// words on the m_ stream (or one stop word, after which all input is dropped
// until reset). The input side takes a byte every cycle; it stalls only on a
// payload byte while both banks hold frames that are still being emitted.
// The result sequencer reads each field byte from the buffer in a read state
// and an accumulate state, emits each result word from an output state and
// passes through an idle state per frame. If 46-byte frames arrive no faster
// than the sequencer drains them, the input waits only when results are held back.
// Configuration words may be written at any time and take effect at once.
module telemetry_frame_deframer #(
    parameter int PAYLOAD_BYTES = 45
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,  // [7:0] rx_byte
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [3:0] field_index, [35:4] field_value, [43:36] frame_type,
    // [51:44] frame_command, [67:52] frame_size, [71:68] zero
    output logic [tfd_pkg::TDATA_W-1:0]        m_tdata,
    output logic                               m_tuser,  // [0] is_stop
    output logic                               m_tlast
);
    import tfd_pkg::*;

    localparam int CNT_W = $clog2(PAYLOAD_BYTES);

    logic             q_full, q_empty, q_push, q_pop;
    job_t             q_job, q_head;
    logic             wr_en, wr_bank;
    logic [CNT_W-1:0] wr_addr;
    logic [7:0]       wr_data;

    assign cfg_ready = 1'b1;

    tfd_front #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job),
        .wr_en     (wr_en),
        .wr_bank   (wr_bank),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    tfd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    tfd_back #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_bank  (wr_bank),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/tfd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfd_front
// Header hunt, payload capture, checksum check and stop detection.
// ----------------------------------------------------------------------------
module tfd_front #(
    parameter int PAYLOAD_BYTES = 45
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    input  wire logic [tfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                   cfg_data,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,
    input  wire logic                         q_full,
    output logic                              q_push,
    output tfd_pkg::job_t                     q_job,
    output logic                              wr_en,
    output logic                              wr_bank,
    output logic [$clog2(PAYLOAD_BYTES)-1:0]  wr_addr,
    output logic [7:0]                        wr_data
);
    import tfd_pkg::*;

    localparam int CNT_W = $clog2(PAYLOAD_BYTES);
    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(PAYLOAD_BYTES - 1);

    logic [7:0]       header_reg, stop_code_reg;
    logic             collecting_reg, collecting_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       xor_reg, xor_next;
    logic             bank_reg, bank_next;
    logic             halted_reg, halted_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [15:0]      size_reg, size_next;
    logic             accept;

    // A payload word may only be taken while a buffer bank is free.
    assign s_tready = halted_reg || !collecting_reg || !q_full;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg    <= HEADER_RESET;
            stop_code_reg <= STOP_CODE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_HEADER_VALUE: header_reg    <= cfg_data;
                CFG_STOP_CODE:    stop_code_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb begin
        collecting_next = collecting_reg;
        count_next      = count_reg;
        xor_next        = xor_reg;
        bank_next       = bank_reg;
        halted_next     = halted_reg;
        type_next       = type_reg;
        cmd_next        = cmd_reg;
        size_next       = size_reg;
        q_push          = 1'b0;
        wr_en           = 1'b0;
        wr_bank         = bank_reg;
        wr_addr         = count_reg;
        wr_data         = s_tdata;
        q_job.bank          = bank_reg;
        q_job.stop          = (cmd_reg == stop_code_reg);
        q_job.frame_type    = type_reg;
        q_job.frame_command = cmd_reg;
        q_job.frame_size    = size_reg;

        if (accept && !halted_reg) begin
            if (!collecting_reg) begin
                if (s_tdata == header_reg) begin
                    collecting_next = 1'b1;
                    count_next      = '0;
                    xor_next        = s_tdata;
                end
            end else begin
                wr_en = 1'b1;
                case (count_reg)
                    CNT_W'(POS_TYPE):    type_next        = s_tdata;
                    CNT_W'(POS_COMMAND): cmd_next         = s_tdata;
                    CNT_W'(POS_SIZE_HI): size_next[15:8]  = s_tdata;
                    CNT_W'(POS_SIZE_LO): size_next[7:0]   = s_tdata;
                    default:             ;
                endcase
                if (count_reg != LAST_POS) begin
                    xor_next   = xor_reg ^ s_tdata;
                    count_next = count_reg + 1'b1;
                end else begin
                    // Checksum word: a mismatch drops the frame without a trace.
                    collecting_next = 1'b0;
                    count_next      = '0;
                    if (s_tdata == xor_reg) begin
                        q_push    = 1'b1;
                        bank_next = !bank_reg;
                        if (cmd_reg == stop_code_reg) begin
                            halted_next = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg <= 1'b0;
            count_reg      <= '0;
            xor_reg        <= '0;
            bank_reg       <= 1'b0;
            halted_reg     <= 1'b0;
        end else begin
            collecting_reg <= collecting_next;
            count_reg      <= count_next;
            xor_reg        <= xor_next;
            bank_reg       <= bank_next;
            halted_reg     <= halted_next;
        end
    end

    always_ff @(posedge aclk) begin
        type_reg <= type_next;
        cmd_reg  <= cmd_next;
        size_reg <= size_next;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/tfd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfd_queue
// Two-entry queue of good frames between the front and the back.
// ----------------------------------------------------------------------------
module tfd_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  tfd_pkg::job_t      push_job,
    input  wire logic          pop,
    output logic               full,
    output logic               empty,
    output tfd_pkg::job_t      head
);
    import tfd_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/tfd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfd_back
// Payload buffer and result sequencer: reads the field bytes of a good frame
// and emits one result word per field, or a single stop result.
// ----------------------------------------------------------------------------
module tfd_back #(
    parameter int PAYLOAD_BYTES = 45
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        wr_en,
    input  wire logic                        wr_bank,
    input  wire logic [$clog2(PAYLOAD_BYTES)-1:0] wr_addr,
    input  wire logic [7:0]                  wr_data,
    input  wire logic                        q_empty,
    input  tfd_pkg::job_t                    q_head,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [tfd_pkg::TDATA_W-1:0]      m_tdata,
    output logic                             m_tuser,
    output logic                             m_tlast
);
    import tfd_pkg::*;

    localparam int MEM_DEPTH = 2 * PAYLOAD_BYTES;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    // Two banks: the front fills one while the back drains the other.
    logic [7:0] mem [MEM_DEPTH];
    logic [7:0] rd_data_reg;
    logic [MEM_AW-1:0] wr_mem_addr, rd_mem_addr;

    back_state_t state_reg, state_next;
    logic [FIELD_ADDR_W-1:0] addr_reg, addr_next;
    logic [3:0]  field_reg, field_next;
    logic [1:0]  byte_reg, byte_next;
    logic [31:0] acc_reg, acc_next;
    logic        out_free, load_out;
    logic        valid_reg, valid_next;
    logic [3:0]  idx_reg, idx_next;
    logic [31:0] value_reg, value_next;
    logic        stop_reg, stop_next, last_reg, last_next;
    logic [7:0]  type_reg, cmd_reg;
    logic [15:0] size_reg;

    assign wr_mem_addr = wr_bank ? MEM_AW'(wr_addr) + MEM_AW'(PAYLOAD_BYTES)
                                 : MEM_AW'(wr_addr);
    assign rd_mem_addr = q_head.bank ? MEM_AW'(addr_reg) + MEM_AW'(PAYLOAD_BYTES)
                                     : MEM_AW'(addr_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_mem_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_mem_addr];
    end

    assign out_free = !valid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    state_next = q_head.stop ? BK_STOP : BK_READ;
                end
            end
            BK_READ: state_next = BK_ACC;
            BK_ACC: begin
                state_next = (byte_reg == field_last_byte(field_reg)) ? BK_OUT : BK_READ;
            end
            BK_OUT: begin
                if (out_free) begin
                    state_next = (field_reg == LAST_FIELD) ? BK_IDLE : BK_READ;
                end
            end
            BK_STOP: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        addr_next  = addr_reg;
        field_next = field_reg;
        byte_next  = byte_reg;
        acc_next   = acc_reg;
        q_pop      = 1'b0;
        load_out   = 1'b0;
        idx_next   = field_reg;
        value_next = acc_reg;
        stop_next  = 1'b0;
        last_next  = (field_reg == LAST_FIELD);
        valid_next = valid_reg && !m_tready;

        case (state_reg)
            BK_IDLE: begin
                addr_next  = FIRST_FIELD_ADDR;
                field_next = '0;
                byte_next  = '0;
            end
            BK_READ: ;
            BK_ACC: begin
                acc_next  = {acc_reg[23:0], rd_data_reg};
                addr_next = addr_reg + 1'b1;
                byte_next = byte_reg + 1'b1;
            end
            BK_OUT: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    valid_next = 1'b1;
                    if (field_last_byte(field_reg) == 2'd1) begin
                        value_next = {{16{acc_reg[15]}}, acc_reg[15:0]};
                    end
                    byte_next  = '0;
                    field_next = field_reg + 1'b1;
                    q_pop      = (field_reg == LAST_FIELD);
                end
            end
            BK_STOP: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    valid_next = 1'b1;
                    idx_next   = '0;
                    value_next = '0;
                    stop_next  = 1'b1;
                    last_next  = 1'b1;
                    q_pop      = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg  <= addr_next;
        field_reg <= field_next;
        byte_reg  <= byte_next;
        acc_reg   <= acc_next;
        if (load_out) begin
            idx_reg   <= idx_next;
            value_reg <= value_next;
            stop_reg  <= stop_next;
            last_reg  <= last_next;
            type_reg  <= q_head.frame_type;
            cmd_reg   <= q_head.frame_command;
            size_reg  <= q_head.frame_size;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, size_reg, cmd_reg, type_reg, value_reg, idx_reg};
    assign m_tuser  = stop_reg;
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the telemetry frame deframer.
// ----------------------------------------------------------------------------
// Bytes go in on the s_ stream in random bursts, and result words are taken
// on the m_ stream under a changing stall pattern. A scoreboard follows the
// hunt, collect and checksum logic byte by byte and queues the words that
// each completed frame should produce. Every result word is compared field
// by field with the oldest queued word. The run steps through several
// header and stop-code settings and ends with a stop frame that halts the
// block, followed by a good frame that the halted block ignores.
// ----------------------------------------------------------------------------
module tb;
    import tfd_pkg::*;

    localparam int PAYLOAD_BYTES = 45;
    // First payload byte after the last telemetry field.
    localparam int FIELD_END     = 36;
    localparam int SETTLE_CYCLES = 100;
    localparam int DRAIN_LIMIT   = 20000;

    // Indexes with no register behind them; writes to them are dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic [3:0]  index;
        logic [31:0] value;
        logic [7:0]  frame_type;
        logic [7:0]  frame_command;
        logic [15:0] frame_size;
        logic        is_stop;
        logic        last;
    } telem_word_t;

    class frame_scoreboard;
        logic [7:0]  header_value;
        logic [7:0]  stop_code;
        bit          collecting;
        bit          halted;
        int          byte_count;
        logic [7:0]  xor_acc;
        logic [7:0]  store [PAYLOAD_BYTES];
        telem_word_t expected_q [$];
        int          errors;
        int          words_checked;
        int          frames_good;
        int          frames_bad;

        function new();
            header_value  = HEADER_RESET;
            stop_code     = STOP_CODE_RESET;
            collecting    = 1'b0;
            halted        = 1'b0;
            byte_count    = 0;
            xor_acc       = 8'h00;
            errors        = 0;
            words_checked = 0;
            frames_good   = 0;
            frames_bad    = 0;
        endfunction

        function void report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
            if (idx == CFG_HEADER_VALUE) begin
                header_value = data;
            end else if (idx == CFG_STOP_CODE) begin
                stop_code = data;
            end
        endfunction

        function void note_rx_byte(logic [7:0] b);
            telem_word_t w;
            int          pos;
            if (halted) return;
            if (!collecting) begin
                // Header value is only looked at while hunting.
                if (b == header_value) begin
                    collecting = 1'b1;
                    byte_count = 0;
                    xor_acc    = b;
                end
                return;
            end
            store[byte_count] = b;
            if (byte_count < PAYLOAD_BYTES - 1) begin
                xor_acc ^= b;
                byte_count++;
                return;
            end
            collecting = 1'b0;
            byte_count = 0;
            if (b != xor_acc) begin
                frames_bad++;
                return;
            end
            frames_good++;
            w.frame_type    = store[POS_TYPE];
            w.frame_command = store[POS_COMMAND];
            w.frame_size    = {store[POS_SIZE_HI], store[POS_SIZE_LO]};
            if (store[POS_COMMAND] == stop_code) begin
                halted    = 1'b1;
                w.index   = 4'd0;
                w.value   = 32'd0;
                w.is_stop = 1'b1;
                w.last    = 1'b1;
                expected_q.push_back(w);
                return;
            end
            // Fields are packed back to back; latitude and longitude take four
            // bytes, the rest two bytes that are sign-extended.
            pos       = FIRST_FIELD_ADDR;
            w.is_stop = 1'b0;
            for (int k = 0; k <= LAST_FIELD; k++) begin
                w.index = 4'(k);
                if (k == FIELD_LAT || k == FIELD_LON) begin
                    w.value = {store[pos], store[pos+1], store[pos+2], store[pos+3]};
                    pos += 4;
                end else begin
                    w.value = {{16{store[pos][7]}}, store[pos], store[pos+1]};
                    pos += 2;
                end
                w.last = (k == LAST_FIELD);
                expected_q.push_back(w);
            end
        endfunction

        function void check_result_word(logic [TDATA_W-1:0] data, logic user,
                                        logic last);
            telem_word_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("result word %h arrived with nothing expected", data));
                return;
            end
            want = expected_q.pop_front();
            words_checked++;
            if (data[3:0] !== want.index)
                report($sformatf("field_index %0d, expected %0d", data[3:0], want.index));
            if (data[35:4] !== want.value)
                report($sformatf("field %0d value %0d, expected %0d", want.index,
                                 $signed(data[35:4]), $signed(want.value)));
            if (data[43:36] !== want.frame_type)
                report($sformatf("frame_type %h, expected %h", data[43:36],
                                 want.frame_type));
            if (data[51:44] !== want.frame_command)
                report($sformatf("frame_command %h, expected %h", data[51:44],
                                 want.frame_command));
            if (data[67:52] !== want.frame_size)
                report($sformatf("frame_size %h, expected %h", data[67:52],
                                 want.frame_size));
            if (data[71:68] !== 4'd0)
                report($sformatf("tdata padding %h is not zero", data[71:68]));
            if (user !== want.is_stop)
                report($sformatf("is_stop %b, expected %b", user, want.is_stop));
            if (last !== want.last)
                report($sformatf("tlast %b on field %0d, expected %b", last,
                                 want.index, want.last));
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = 8'h00;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'h00;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    frame_scoreboard board;
    int              bytes_sent  = 0;
    int              burst_left  = 0;
    logic [6:0]      rx_cycle    = '0;
    logic [1:0]      rx_mode     = 2'd0;
    logic [7:0]      body [PAYLOAD_BYTES-1];
    logic [7:0]      frame_q [$];

    telemetry_frame_deframer #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Receiver: a new stall pattern is picked each time the 7-bit rx_cycle counter wraps.
    always @(negedge aclk) begin
        if (rx_cycle == '0) begin
            rx_mode <= 2'($urandom_range(0, 3));
        end
        rx_cycle <= rx_cycle + 7'd1;
        case (rx_mode)
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (rx_cycle[4:0] >= 5'd24);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result_word(m_tdata, m_tuser, m_tlast);
        end
    end

    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 30);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        board.note_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        board.apply_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        int guard;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        guard = 0;
        while (board.pending() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        if (board.pending() != 0) begin
            board.report($sformatf("%0d result words never arrived", board.pending()));
            board.expected_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic void random_body();
        for (int i = 0; i < PAYLOAD_BYTES - 1; i++) body[i] = 8'($urandom);
    endfunction

    // Extreme field values; the header value also sits inside the payload.
    function automatic void extreme_body(input bit negative);
        for (int i = 0; i < PAYLOAD_BYTES - 1; i++) body[i] = negative ? 8'h00 : 8'hFF;
        body[POS_TYPE]    = negative ? 8'hFF : 8'h00;
        body[POS_COMMAND] = negative ? 8'h00 : 8'hFF;
        body[POS_SIZE_HI] = negative ? 8'hFF : 8'h00;
        body[POS_SIZE_LO] = negative ? 8'hFF : 8'h00;
        body[POS_SIZE_LO + 1] = board.header_value;
        for (int p = FIRST_FIELD_ADDR; p < FIELD_END; p += 2) begin
            body[p]   = negative ? 8'h80 : 8'h7F;
            body[p+1] = negative ? 8'h00 : 8'hFF;
        end
        // Make the two wide fields read as the full int32 extremes.
        body[26] = negative ? 8'h00 : 8'hFF;
        body[30] = negative ? 8'h00 : 8'hFF;
    endfunction

    function automatic void build_frame(input logic [7:0] hdr, input bit corrupt);
        logic [7:0] sum;
        sum = hdr;
        frame_q.delete();
        frame_q.push_back(hdr);
        for (int i = 0; i < PAYLOAD_BYTES - 1; i++) begin
            frame_q.push_back(body[i]);
            sum ^= body[i];
        end
        if (corrupt) sum ^= 8'($urandom_range(1, 255));
        frame_q.push_back(sum);
    endfunction

    task automatic send_bytes(input int n);
        repeat (n) begin
            if (frame_q.size() != 0) push_byte(frame_q.pop_front());
        end
    endtask

    initial begin
        board = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Lone bytes while hunting, then extreme frames at reset settings.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h5A);
        extreme_body(1'b1);
        build_frame(board.header_value, 1'b0);
        send_bytes(frame_q.size());
        extreme_body(1'b0);
        build_frame(board.header_value, 1'b0);
        send_bytes(frame_q.size());
        // A stop command with a bad checksum must be dropped.
        random_body();
        body[POS_COMMAND] = board.stop_code;
        build_frame(board.header_value, 1'b1);
        send_bytes(frame_q.size());

        wait_drained();
        write_reg(CFG_SPARE_A, 8'h00);
        write_reg(CFG_SPARE_B, 8'hFF);
        // Registers change in the middle of a frame that carries the old
        // stop code: the frame keeps its header and is not a stop.
        random_body();
        body[POS_COMMAND] = board.stop_code;
        build_frame(board.header_value, 1'b0);
        send_bytes(12);
        wait_drained();
        write_reg(CFG_HEADER_VALUE, 8'h00);
        write_reg(CFG_STOP_CODE, 8'hFF);
        send_bytes(frame_q.size());

        wait_drained();
        write_reg(CFG_HEADER_VALUE, 8'($urandom));
        write_reg(CFG_STOP_CODE, 8'($urandom));

        // Stop frame, then a good frame that the halted block must ignore.
        random_body();
        body[POS_COMMAND] = board.stop_code;
        build_frame(board.header_value, 1'b0);
        send_bytes(frame_q.size());
        random_body();
        body[POS_COMMAND] = ~board.stop_code;
        build_frame(board.header_value, 1'b0);
        send_bytes(frame_q.size());
        wait_drained();

        $display("run covered %0d bytes in, %0d good frames, %0d checksum failures, %0d words",
                 bytes_sent, board.frames_good, board.frames_bad, board.words_checked);
        $display("header and stop code went through reset, zero or all-ones, and random values");
        if (board.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("timeout with %0d words outstanding", board.pending());
        $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/tfd_pkg.sv
hw/rtl/tfd_front.sv
hw/rtl/tfd_queue.sv
hw/rtl/tfd_back.sv
hw/rtl/telemetry_frame_deframer.sv
test/tb.sv
